>>> hdl/cadeec_pkg.sv
package cadeec_pkg;

   localparam int COORD_W = 32;
   localparam int ANGLE_W = 25;
   localparam int RADIUS_W = 31;
   localparam int WIDE_W = 64;
   localparam int Z_W = 32;
   localparam int GUARD = 61 - COORD_W;
   localparam int N_ITER = 23;
   localparam int ITER_W = 5;
   localparam int MAG_W = 34;

   localparam logic [1:0] KIND_LINE = 2'd0;
   localparam logic [1:0] KIND_ARC = 2'd1;
   localparam logic [1:0] KIND_CIRCLE = 2'd2;
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   localparam logic [ANGLE_W-1:0] FULL_TURN = 25'd23592960;
   localparam logic signed [Z_W-1:0] DEG90 = 32'sd5898240;
   localparam logic signed [Z_W-1:0] DEG180 = 32'sd11796480;
   localparam logic signed [Z_W-1:0] DEG270 = 32'sd17694720;
   localparam logic signed [Z_W-1:0] DEG360 = 32'sd23592960;

   // CORDIC gain in Q30, and its rounded half for the low radius bit
   localparam logic [29:0] CORDIC_K = 30'd652032874;
   localparam logic [WIDE_W-1:0] HALF_K = 64'd326016437;
   localparam logic signed [WIDE_W-1:0] ROUND_BIAS = 64'sd1 <<< (GUARD - 1);
   localparam logic [MAG_W-1:0] MAG_LO = 34'd1 << 29;
   localparam logic [MAG_W-1:0] MAG_HI = 34'd1 << 30;

   typedef enum logic [3:0] {
      OP_NOP, OP_CAPTURE, OP_ROT_SETUP, OP_SCALE, OP_ROT_STEP, OP_ROT_FIN, OP_STORE,
      OP_VEC_INIT, OP_NORM, OP_VEC_PREP, OP_VEC_STEP, OP_VEC_FIN, OP_AXIS, OP_EMIT
   } op_type;

   typedef enum logic [1:0] {
      ANG_START, ANG_END, ANG_PHI
   } ang_type;

   typedef struct packed {
      op_type  op;
      ang_type ang;
   } dp_cmd_type;

   typedef struct packed {
      logic       at_origin;
      logic       on_axis;
      logic       norm_done;
      logic       iter_last;
      logic       out_busy;
   } dp_stat_type;

   function automatic logic signed [Z_W-1:0] arctan(input logic [ITER_W-1:0] idx);
      logic signed [Z_W-1:0] v;
      case (idx)
         5'd0: v = 32'sd2949120;
         5'd1: v = 32'sd1740967;
         5'd2: v = 32'sd919879;
         5'd3: v = 32'sd466945;
         5'd4: v = 32'sd234379;
         5'd5: v = 32'sd117304;
         5'd6: v = 32'sd58666;
         5'd7: v = 32'sd29335;
         5'd8: v = 32'sd14668;
         5'd9: v = 32'sd7334;
         5'd10: v = 32'sd3667;
         5'd11: v = 32'sd1833;
         5'd12: v = 32'sd917;
         5'd13: v = 32'sd458;
         5'd14: v = 32'sd229;
         5'd15: v = 32'sd115;
         5'd16: v = 32'sd57;
         5'd17: v = 32'sd29;
         5'd18: v = 32'sd14;
         5'd19: v = 32'sd7;
         5'd20: v = 32'sd4;
         5'd21: v = 32'sd2;
         5'd22: v = 32'sd1;
         default: v = 32'sd0;
      endcase
      return v;
   endfunction

   function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [WIDE_W-1:0] v);
      logic signed [WIDE_W-1:0] hi;
      logic signed [WIDE_W-1:0] lo;
      logic signed [COORD_W-1:0] r;
      hi = (64'sd1 <<< (COORD_W - 1)) - 64'sd1;
      lo = -hi - 64'sd1;
      if (v > hi) r = hi[COORD_W-1:0];
      else if (v < lo) r = lo[COORD_W-1:0];
      else r = v[COORD_W-1:0];
      return r;
   endfunction

endpackage

>>> hdl/cadeec_ctrl.sv
module cadeec_ctrl import cadeec_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic [1:0]  req_cmd,
   output logic        req_stall,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   typedef enum logic [12:0] {
      S_IDLE      = 13'b0000000000001,
      S_ROT_SETUP = 13'b0000000000010,
      S_SCALE     = 13'b0000000000100,
      S_ROT       = 13'b0000000001000,
      S_ROT_FIN   = 13'b0000000010000,
      S_STORE     = 13'b0000000100000,
      S_VEC_INIT  = 13'b0000001000000,
      S_NORM      = 13'b0000010000000,
      S_VEC_PREP  = 13'b0000100000000,
      S_VEC       = 13'b0001000000000,
      S_VEC_FIN   = 13'b0010000000000,
      S_AXIS      = 13'b0100000000000,
      S_EMIT      = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;
   ang_type   ang_ff, ang_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      ang_in = ang_ff;
      cmd.op = OP_NOP;
      cmd.ang = ang_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_cmd != KIND_UNUSED) begin
               cmd.op = OP_CAPTURE;
               if (req_cmd == KIND_LINE) begin
                  state_in = S_EMIT;
               end else if (req_cmd == KIND_ARC) begin
                  ang_in = ANG_START;
                  state_in = S_ROT_SETUP;
               end else begin
                  ang_in = ANG_PHI;
                  state_in = S_VEC_INIT;
               end
            end
         end
         S_ROT_SETUP: begin
            cmd.op = OP_ROT_SETUP;
            state_in = S_SCALE;
         end
         S_SCALE: begin
            cmd.op = OP_SCALE;
            state_in = S_ROT;
         end
         S_ROT: begin
            cmd.op = OP_ROT_STEP;
            if (stat.iter_last) state_in = S_ROT_FIN;
         end
         S_ROT_FIN: begin
            cmd.op = OP_ROT_FIN;
            state_in = S_STORE;
         end
         S_STORE: begin
            cmd.op = OP_STORE;
            if (ang_ff == ANG_START) begin
               ang_in = ANG_END;
               state_in = S_ROT_SETUP;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_VEC_INIT: begin
            if (stat.at_origin) begin
               state_in = S_EMIT;
            end else if (stat.on_axis) begin
               state_in = S_AXIS;
            end else begin
               cmd.op = OP_VEC_INIT;
               state_in = S_NORM;
            end
         end
         S_NORM: begin
            if (stat.norm_done) state_in = S_VEC_PREP;
            else cmd.op = OP_NORM;
         end
         S_VEC_PREP: begin
            cmd.op = OP_VEC_PREP;
            state_in = S_VEC;
         end
         S_VEC: begin
            cmd.op = OP_VEC_STEP;
            if (stat.iter_last) state_in = S_VEC_FIN;
         end
         S_VEC_FIN: begin
            cmd.op = OP_VEC_FIN;
            state_in = S_ROT_SETUP;
         end
         S_AXIS: begin
            cmd.op = OP_AXIS;
            state_in = S_ROT_SETUP;
         end
         S_EMIT: begin
            // hold until the output register is free
            if (!stat.out_busy) begin
               cmd.op = OP_EMIT;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ang_ff <= ANG_START;
      end else begin
         state_ff <= state_in;
         ang_ff <= ang_in;
      end
   end

endmodule

>>> hdl/cadeec_dp.sv
module cadeec_dp import cadeec_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  dp_cmd_type                cmd,
   output dp_stat_type               stat,
   input  logic [1:0]                req_cmd,
   input  logic signed [COORD_W-1:0] req_line_start_x,
   input  logic signed [COORD_W-1:0] req_line_start_y,
   input  logic signed [COORD_W-1:0] req_line_end_x,
   input  logic signed [COORD_W-1:0] req_line_end_y,
   input  logic signed [COORD_W-1:0] req_center_x,
   input  logic signed [COORD_W-1:0] req_center_y,
   input  logic [RADIUS_W-1:0]       req_radius,
   input  logic [ANGLE_W-1:0]        req_arc_start_deg,
   input  logic [ANGLE_W-1:0]        req_arc_end_deg,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [1:0]                rsp_kind,
   output logic signed [COORD_W-1:0] rsp_start_x,
   output logic signed [COORD_W-1:0] rsp_start_y,
   output logic signed [COORD_W-1:0] rsp_end_x,
   output logic signed [COORD_W-1:0] rsp_end_y,
   output logic [ANGLE_W-1:0]        rsp_pierce_angle,
   output logic                      rsp_degenerate,
   output logic [31:0]               rsp_element_id,
   output logic [31:0]               rsp_loop_id
);

   logic [1:0]                kind_ff;
   logic signed [COORD_W-1:0] lsx_ff, lsy_ff, lex_ff, ley_ff, cx_ff, cy_ff;
   logic [RADIUS_W-1:0]       r_ff;
   logic [ANGLE_W-1:0]        a0_ff, a1_ff, phi_ff;
   logic signed [WIDE_W-1:0]  x_ff, y_ff, c_ff, s_ff;
   logic signed [Z_W-1:0]     z_ff;
   logic [MAG_W-1:0]          m_ff;
   logic [ITER_W-1:0]         i_ff;
   logic                      neg_ff, base_ff;
   logic signed [COORD_W-1:0] psx_ff, psy_ff, pex_ff, pey_ff;
   logic                      valid_ff;
   logic [31:0]               elem_ff, loop_ff;

   logic [ANGLE_W-1:0]        a0_red, a1_red, theta;
   logic signed [Z_W-1:0]     zs, at, zt;
   logic signed [WIDE_W-1:0]  xsh, ysh, xn, yn, cxw, cyw, vx, vy, ax, ay;
   logic [59:0]               prod;

   assign a0_red = (req_arc_start_deg >= FULL_TURN) ? req_arc_start_deg - FULL_TURN
                                                    : req_arc_start_deg;
   assign a1_red = (req_arc_end_deg >= FULL_TURN) ? req_arc_end_deg - FULL_TURN
                                                  : req_arc_end_deg;

   always_comb begin
      case (cmd.ang)
         ANG_START: theta = a0_ff;
         ANG_END:   theta = a1_ff;
         default:   theta = phi_ff;
      endcase
      zs = signed'({7'd0, theta});
      if (zs >= DEG180) zs = zs - DEG360;
   end

   assign at = arctan(i_ff);
   assign xsh = x_ff >>> i_ff;
   assign ysh = y_ff >>> i_ff;
   assign prod = r_ff[RADIUS_W-1:1] * CORDIC_K;
   assign xn = neg_ff ? -x_ff : x_ff;
   assign yn = neg_ff ? -y_ff : y_ff;
   assign cxw = WIDE_W'(cx_ff);
   assign cyw = WIDE_W'(cy_ff);
   assign vx = -cxw;
   assign vy = -cyw;
   assign ax = (vx < 0) ? -vx : vx;
   assign ay = (vy < 0) ? -vy : vy;
   assign zt = z_ff + (base_ff ? DEG180 : 32'sd0);

   assign stat.at_origin = (cx_ff == '0) && (cy_ff == '0);
   assign stat.on_axis = (cx_ff == '0) || (cy_ff == '0);
   assign stat.norm_done = (m_ff >= MAG_LO) && (m_ff < MAG_HI);
   assign stat.iter_last = (i_ff == ITER_W'(N_ITER - 1));
   assign stat.out_busy = valid_ff && rsp_stall;

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_CAPTURE: begin
            kind_ff <= req_cmd;
            lsx_ff <= req_line_start_x;
            lsy_ff <= req_line_start_y;
            lex_ff <= req_line_end_x;
            ley_ff <= req_line_end_y;
            cx_ff <= req_center_x;
            cy_ff <= req_center_y;
            r_ff <= req_radius;
            a0_ff <= a0_red;
            a1_ff <= a1_red;
         end
         OP_ROT_SETUP: begin
            if (zs > DEG90) begin
               z_ff <= zs - DEG180;
               neg_ff <= 1'b1;
            end else if (zs < -DEG90) begin
               z_ff <= zs + DEG180;
               neg_ff <= 1'b1;
            end else begin
               z_ff <= zs;
               neg_ff <= 1'b0;
            end
         end
         OP_SCALE: begin
            x_ff <= signed'(WIDE_W'(prod) + (r_ff[0] ? HALF_K : '0));
            y_ff <= '0;
            i_ff <= '0;
         end
         OP_ROT_STEP: begin
            if (z_ff >= 0) begin
               x_ff <= x_ff - ysh;
               y_ff <= y_ff + xsh;
               z_ff <= z_ff - at;
            end else begin
               x_ff <= x_ff + ysh;
               y_ff <= y_ff - xsh;
               z_ff <= z_ff + at;
            end
            i_ff <= i_ff + 1'b1;
         end
         OP_ROT_FIN: begin
            c_ff <= (xn + ROUND_BIAS) >>> GUARD;
            s_ff <= (yn + ROUND_BIAS) >>> GUARD;
         end
         OP_STORE: begin
            case (cmd.ang)
               ANG_START: begin
                  psx_ff <= sat_coord(cxw + c_ff);
                  psy_ff <= sat_coord(cyw - s_ff);
               end
               ANG_END: begin
                  pex_ff <= sat_coord(cxw + c_ff);
                  pey_ff <= sat_coord(cyw - s_ff);
               end
               default: begin
                  psx_ff <= sat_coord(cxw + c_ff);
                  psy_ff <= sat_coord(cyw + s_ff);
                  pex_ff <= sat_coord(cxw + c_ff);
                  pey_ff <= sat_coord(cyw + s_ff);
               end
            endcase
         end
         OP_VEC_INIT: begin
            x_ff <= vx;
            y_ff <= vy;
            m_ff <= (ax > ay) ? ax[MAG_W-1:0] : ay[MAG_W-1:0];
         end
         OP_NORM: begin
            // one bit per cycle until the larger magnitude sits in [2^29, 2^30)
            if (m_ff >= MAG_HI) begin
               x_ff <= x_ff >>> 1;
               y_ff <= y_ff >>> 1;
               m_ff <= m_ff >> 1;
            end else begin
               x_ff <= x_ff <<< 1;
               y_ff <= y_ff <<< 1;
               m_ff <= m_ff << 1;
            end
         end
         OP_VEC_PREP: begin
            if (x_ff < 0) begin
               x_ff <= -x_ff;
               y_ff <= -y_ff;
               base_ff <= 1'b1;
            end else begin
               base_ff <= 1'b0;
            end
            z_ff <= '0;
            i_ff <= '0;
         end
         OP_VEC_STEP: begin
            if (y_ff > 0) begin
               x_ff <= x_ff + ysh;
               y_ff <= y_ff - xsh;
               z_ff <= z_ff + at;
            end else begin
               x_ff <= x_ff - ysh;
               y_ff <= y_ff + xsh;
               z_ff <= z_ff - at;
            end
            i_ff <= i_ff + 1'b1;
         end
         OP_VEC_FIN: begin
            if (zt < 0) phi_ff <= ANGLE_W'(zt + DEG360);
            else if (zt >= DEG360) phi_ff <= ANGLE_W'(zt - DEG360);
            else phi_ff <= ANGLE_W'(zt);
         end
         OP_AXIS: begin
            // direction from the center toward the origin
            if (cy_ff == '0) phi_ff <= (cx_ff < 0) ? '0 : ANGLE_W'(DEG180);
            else phi_ff <= (cy_ff < 0) ? ANGLE_W'(DEG90) : ANGLE_W'(DEG270);
         end
         OP_EMIT: begin
            rsp_kind <= kind_ff;
            rsp_pierce_angle <= '0;
            rsp_degenerate <= 1'b0;
            if (kind_ff == KIND_LINE) begin
               rsp_start_x <= lsx_ff;
               rsp_start_y <= lsy_ff;
               rsp_end_x <= lex_ff;
               rsp_end_y <= ley_ff;
            end else if (kind_ff == KIND_CIRCLE && stat.at_origin) begin
               rsp_start_x <= '0;
               rsp_start_y <= '0;
               rsp_end_x <= '0;
               rsp_end_y <= '0;
               rsp_degenerate <= 1'b1;
            end else begin
               rsp_start_x <= psx_ff;
               rsp_start_y <= psy_ff;
               rsp_end_x <= pex_ff;
               rsp_end_y <= pey_ff;
               if (kind_ff == KIND_CIRCLE) rsp_pierce_angle <= phi_ff;
            end
            rsp_element_id <= elem_ff + 32'd1;
            rsp_loop_id <= (kind_ff == KIND_CIRCLE) ? loop_ff + 32'd1 : 32'd1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         elem_ff <= '0;
         loop_ff <= '0;
      end else begin
         if (cmd.op == OP_EMIT) begin
            valid_ff <= 1'b1;
            elem_ff <= elem_ff + 32'd1;
            loop_ff <= (kind_ff == KIND_CIRCLE) ? loop_ff + 32'd1 : 32'd1;
         end else if (!rsp_stall) begin
            valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = valid_ff;

endmodule

>>> hdl/cad_entity_endpoint_converter.sv
// channel   | valid     | stall     | beat
// request   | req_valid | req_stall | req_cmd, line_*, center_*, radius, arc_*_deg
// response  | rsp_valid | rsp_stall | rsp_kind, points, pierce_angle, degenerate, ids
//
// One item at a time. A line passes straight through; an arc takes two passes of
// the shared 23-step CORDIC, each with a radius pre-scale multiply; a circle at the
// origin takes no pass, one centered on an axis only a rotation pass, else the
// one-bit-per-cycle normalize loop (up to 29 shifts) plus a 23-step vectoring
// pass and a rotation pass. Synchronous reset clears the counters and control.
// A result waits in the output register under rsp_stall while the next beat is taken.
module cad_entity_endpoint_converter import cadeec_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [1:0]                req_cmd,
   input  logic signed [COORD_W-1:0] req_line_start_x,
   input  logic signed [COORD_W-1:0] req_line_start_y,
   input  logic signed [COORD_W-1:0] req_line_end_x,
   input  logic signed [COORD_W-1:0] req_line_end_y,
   input  logic signed [COORD_W-1:0] req_center_x,
   input  logic signed [COORD_W-1:0] req_center_y,
   input  logic [RADIUS_W-1:0]       req_radius,
   input  logic [ANGLE_W-1:0]        req_arc_start_deg,
   input  logic [ANGLE_W-1:0]        req_arc_end_deg,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [1:0]                rsp_kind,
   output logic signed [COORD_W-1:0] rsp_start_x,
   output logic signed [COORD_W-1:0] rsp_start_y,
   output logic signed [COORD_W-1:0] rsp_end_x,
   output logic signed [COORD_W-1:0] rsp_end_y,
   output logic [ANGLE_W-1:0]        rsp_pierce_angle,
   output logic                      rsp_degenerate,
   output logic [31:0]               rsp_element_id,
   output logic [31:0]               rsp_loop_id
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   cadeec_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   cadeec_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_cmd           (req_cmd),
      .req_line_start_x  (req_line_start_x),
      .req_line_start_y  (req_line_start_y),
      .req_line_end_x    (req_line_end_x),
      .req_line_end_y    (req_line_end_y),
      .req_center_x      (req_center_x),
      .req_center_y      (req_center_y),
      .req_radius        (req_radius),
      .req_arc_start_deg (req_arc_start_deg),
      .req_arc_end_deg   (req_arc_end_deg),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_kind          (rsp_kind),
      .rsp_start_x       (rsp_start_x),
      .rsp_start_y       (rsp_start_y),
      .rsp_end_x         (rsp_end_x),
      .rsp_end_y         (rsp_end_y),
      .rsp_pierce_angle  (rsp_pierce_angle),
      .rsp_degenerate    (rsp_degenerate),
      .rsp_element_id    (rsp_element_id),
      .rsp_loop_id       (rsp_loop_id)
   );

endmodule

>>> tb/cadeec_checker.sv
`timescale 1ns / 1ps
module cadeec_checker import cadeec_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_stall,
   input  logic [1:0]                req_cmd,
   input  logic signed [COORD_W-1:0] req_line_start_x,
   input  logic signed [COORD_W-1:0] req_line_start_y,
   input  logic signed [COORD_W-1:0] req_line_end_x,
   input  logic signed [COORD_W-1:0] req_line_end_y,
   input  logic signed [COORD_W-1:0] req_center_x,
   input  logic signed [COORD_W-1:0] req_center_y,
   input  logic [RADIUS_W-1:0]       req_radius,
   input  logic [ANGLE_W-1:0]        req_arc_start_deg,
   input  logic [ANGLE_W-1:0]        req_arc_end_deg,
   input  logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  logic [1:0]                rsp_kind,
   input  logic signed [COORD_W-1:0] rsp_start_x,
   input  logic signed [COORD_W-1:0] rsp_start_y,
   input  logic signed [COORD_W-1:0] rsp_end_x,
   input  logic signed [COORD_W-1:0] rsp_end_y,
   input  logic [ANGLE_W-1:0]        rsp_pierce_angle,
   input  logic                      rsp_degenerate,
   input  logic [31:0]               rsp_element_id,
   input  logic [31:0]               rsp_loop_id,
   output int                        errors,
   output int                        pending,
   output int                        circles_seen,
   output int                        arcs_seen
);

   typedef struct {
      logic [1:0]         kind;
      logic [COORD_W-1:0] sx, sy, ex, ey;
      logic [ANGLE_W-1:0] pierce;
      logic               degen;
      logic [31:0]        eid, lid;
   } endpoint_type;

   localparam longint TURN = 64'sd23592960;
   localparam longint HALF_TURN = 64'sd11796480;
   localparam longint QUARTER = 64'sd5898240;
   localparam longint ATAN [23] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1};

   endpoint_type endpoint_q[$];
   logic [31:0]  elem_cnt, loop_cnt;

   function automatic logic [COORD_W-1:0] clamp32(longint v);
      if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return v[31:0];
   endfunction

   // r*cos(theta), r*sin(theta) via scaled-radius CORDIC rotation
   function automatic void rotate_vec(longint unsigned r, longint theta,
                                      output longint c, output longint s);
      longint unsigned v, vh, vl;
      longint x, y, z, nx, ny;
      logic neg;
      v = r << GUARD;
      vh = v >> 30;
      vl = v & 64'h3FFF_FFFF;
      x = longint'(vh * 64'd652032874 + ((vl * 64'd652032874 + 64'h2000_0000) >> 30));
      y = 0;
      z = theta;
      neg = 1'b0;
      if (z >= HALF_TURN) z -= TURN;
      if (z > QUARTER) begin
         z -= HALF_TURN;
         neg = 1'b1;
      end else if (z < -QUARTER) begin
         z += HALF_TURN;
         neg = 1'b1;
      end
      for (int i = 0; i < 23; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i); ny = y + (x >>> i); z -= ATAN[i];
         end else begin
            nx = x + (y >>> i); ny = y - (x >>> i); z += ATAN[i];
         end
         x = nx; y = ny;
      end
      if (neg) begin
         x = -x; y = -y;
      end
      c = (x + (64'sd1 <<< (GUARD - 1))) >>> GUARD;
      s = (y + (64'sd1 <<< (GUARD - 1))) >>> GUARD;
   endfunction

   function automatic longint heading(longint px, longint py);
      longint x, y, z, base, nx, ny, ax, ay, m;
      x = px; y = py; z = 0; base = 0;
      if (y == 0) return (x > 0) ? 0 : HALF_TURN;
      if (x == 0) return (y > 0) ? QUARTER : HALF_TURN + QUARTER;
      ax = (x < 0) ? -x : x;
      ay = (y < 0) ? -y : y;
      m = (ax > ay) ? ax : ay;
      while (m >= (64'sd1 <<< 30)) begin
         x = x >>> 1; y = y >>> 1; m = m >>> 1;
      end
      while (m < (64'sd1 <<< 29)) begin
         x = x * 2; y = y * 2; m = m * 2;
      end
      if (x < 0) begin
         x = -x; y = -y; base = HALF_TURN;
      end
      for (int i = 0; i < 23; i++) begin
         if (y > 0) begin
            nx = x + (y >>> i); ny = y - (x >>> i); z += ATAN[i];
         end else begin
            nx = x - (y >>> i); ny = y + (x >>> i); z -= ATAN[i];
         end
         x = nx; y = ny;
      end
      z += base;
      if (z < 0) z += TURN;
      if (z >= TURN) z -= TURN;
      return z;
   endfunction

   function automatic longint wrap_angle(logic [ANGLE_W-1:0] a);
      longint v;
      v = longint'(a);
      if (v >= TURN) v -= TURN;
      return v;
   endfunction

   task automatic predict_endpoints();
      endpoint_type e;
      longint cx, cy, c, s, phi;
      longint unsigned r;
      cx = longint'(req_center_x);
      cy = longint'(req_center_y);
      r = longint'(req_radius);
      e = '{kind: req_cmd, default: '0};
      elem_cnt = elem_cnt + 1;
      case (req_cmd)
         KIND_LINE: begin
            e.sx = req_line_start_x; e.sy = req_line_start_y;
            e.ex = req_line_end_x;   e.ey = req_line_end_y;
            loop_cnt = 1;
         end
         KIND_ARC: begin
            rotate_vec(r, wrap_angle(req_arc_start_deg), c, s);
            e.sx = clamp32(cx + c); e.sy = clamp32(cy - s);
            rotate_vec(r, wrap_angle(req_arc_end_deg), c, s);
            e.ex = clamp32(cx + c); e.ey = clamp32(cy - s);
            loop_cnt = 1;
            arcs_seen++;
         end
         default: begin
            if (cx == 0 && cy == 0) begin
               e.degen = 1'b1;
            end else begin
               phi = heading(-cx, -cy);
               rotate_vec(r, phi, c, s);
               e.sx = clamp32(cx + c); e.sy = clamp32(cy + s);
               e.ex = e.sx; e.ey = e.sy;
               e.pierce = phi[ANGLE_W-1:0];
            end
            loop_cnt = loop_cnt + 1;
            circles_seen++;
         end
      endcase
      e.eid = elem_cnt;
      e.lid = loop_cnt;
      endpoint_q.push_back(e);
   endtask

   task automatic compare_beat();
      endpoint_type e;
      logic bad;
      if (endpoint_q.size() == 0) begin
         errors++;
         if (errors <= 10) $display("%0t: result beat with nothing expected", $realtime);
         return;
      end
      e = endpoint_q.pop_front();
      bad = (rsp_kind !== e.kind) || (rsp_start_x !== e.sx) || (rsp_start_y !== e.sy)
         || (rsp_end_x !== e.ex) || (rsp_end_y !== e.ey) || (rsp_pierce_angle !== e.pierce)
         || (rsp_degenerate !== e.degen) || (rsp_element_id !== e.eid)
         || (rsp_loop_id !== e.lid);
      if (bad) begin
         errors++;
         if (errors <= 10) begin
            $display("%0t: mismatch element %0d", $realtime, e.eid);
            $display("  exp kind %0d s(%h,%h) e(%h,%h) ang %h dg %b id %0d loop %0d",
                     e.kind, e.sx, e.sy, e.ex, e.ey, e.pierce, e.degen, e.eid, e.lid);
            $display("  got kind %0d s(%h,%h) e(%h,%h) ang %h dg %b id %0d loop %0d",
                     rsp_kind, rsp_start_x, rsp_start_y, rsp_end_x, rsp_end_y,
                     rsp_pierce_angle, rsp_degenerate, rsp_element_id, rsp_loop_id);
         end
      end
   endtask

   initial begin
      errors = 0;
      circles_seen = 0;
      arcs_seen = 0;
      elem_cnt = '0;
      loop_cnt = '0;
   end

   always @(posedge clock) begin
      if (reset) begin
         elem_cnt = '0;
         loop_cnt = '0;
         endpoint_q.delete();
      end else begin
         if (req_valid && !req_stall && req_cmd != KIND_UNUSED) predict_endpoints();
         if (rsp_valid && !rsp_stall) compare_beat();
      end
      pending = endpoint_q.size();
   end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
module tb;
   import cadeec_pkg::*;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [1:0]                req_cmd = KIND_LINE;
   logic signed [COORD_W-1:0] req_line_start_x = '0, req_line_start_y = '0;
   logic signed [COORD_W-1:0] req_line_end_x = '0, req_line_end_y = '0;
   logic signed [COORD_W-1:0] req_center_x = '0, req_center_y = '0;
   logic [RADIUS_W-1:0]       req_radius = '0;
   logic [ANGLE_W-1:0]        req_arc_start_deg = '0, req_arc_end_deg = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [1:0]                rsp_kind;
   logic signed [COORD_W-1:0] rsp_start_x, rsp_start_y, rsp_end_x, rsp_end_y;
   logic [ANGLE_W-1:0]        rsp_pierce_angle;
   logic                      rsp_degenerate;
   logic [31:0]               rsp_element_id, rsp_loop_id;
   int                        errors, pending, circles_seen, arcs_seen;
   int                        sent = 0;
   longint                    cycle = 0;

   always #2 clock = ~clock;

   cad_entity_endpoint_converter dut (.*);
   cadeec_checker u_checker (.*);

   // receiver: random stall, one long hold-off, one quiet stretch
   always @(posedge clock) begin
      cycle <= cycle + 1;
      if (reset) rsp_stall <= 1'b0;
      else if (cycle >= 20000 && cycle < 20600) rsp_stall <= 1'b1;
      else if (cycle >= 40000 && cycle < 50000) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(99) < 22);
   end

   function automatic logic [31:0] pick_coord();
      case ($urandom_range(5))
         0: return $urandom;
         1: return (($urandom_range(1)) ? 32'h7FFF_FFFF : 32'h8000_0000);
         2: return 32'($signed($urandom_range(0, 32'h3FF)) - 512) <<< 16;
         default: return 32'($signed($urandom_range(0, 32'h0FFF_FFFF)) - 32'sh0800_0000);
      endcase
   endfunction

   function automatic logic [RADIUS_W-1:0] pick_radius();
      case ($urandom_range(4))
         0: return RADIUS_W'($urandom);
         1: return '0;
         2: return {RADIUS_W{1'b1}};
         default: return RADIUS_W'($urandom_range(0, 32'h07FF_FFFF));
      endcase
   endfunction

   function automatic logic [ANGLE_W-1:0] pick_angle();
      case ($urandom_range(3))
         0: return ANGLE_W'($urandom);
         1: return 25'($urandom_range(0, 4) * 5898240);
         default: return ANGLE_W'($urandom_range(0, 23592959));
      endcase
   endfunction

   task automatic send_entity(logic [1:0] k, logic [31:0] lsx, lsy, lex, ley, cx, cy,
                              logic [RADIUS_W-1:0] r, logic [ANGLE_W-1:0] a0, a1,
                              bit gaps);
      int gap;
      req_cmd <= k;
      req_line_start_x <= lsx; req_line_start_y <= lsy;
      req_line_end_x <= lex;   req_line_end_y <= ley;
      req_center_x <= cx;      req_center_y <= cy;
      req_radius <= r;
      req_arc_start_deg <= a0; req_arc_end_deg <= a1;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (k != KIND_UNUSED) sent++;
      if (gaps && $urandom_range(99) < 22) begin
         gap = $urandom_range(1, 12);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_random(bit gaps);
      logic [1:0] k;
      int sel;
      logic [31:0] cx, cy;
      sel = $urandom_range(99);
      k = (sel < 30) ? KIND_LINE : (sel < 62) ? KIND_ARC : (sel < 97) ? KIND_CIRCLE
          : KIND_UNUSED;
      cx = pick_coord();
      cy = pick_coord();
      // push some circles onto an axis or the origin
      if (k == KIND_CIRCLE && $urandom_range(9) == 0) cx = '0;
      if (k == KIND_CIRCLE && $urandom_range(9) == 0) cy = '0;
      send_entity(k, pick_coord(), pick_coord(), pick_coord(), pick_coord(), cx, cy,
                  pick_radius(), pick_angle(), pick_angle(), gaps);
   endtask

   initial begin
      #4_000_000;
      $display("timeout with %0d results outstanding", pending);
      $display("FAIL cad_entity_endpoint_converter");
      $finish;
   end

   initial begin
      int waited;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: extremes, each kind, wrap, axes, origin, zero radius, unused kind
      send_entity(KIND_LINE, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0, 0, 0, 0,
                  0, 0, 1'b0);
      send_entity(KIND_LINE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF, 0, 0, 0,
                  0, 0, 1'b0);
      send_entity(KIND_ARC, 0, 0, 0, 0, 32'h0001_0000, 32'h0002_0000, 31'h0005_0000,
                  0, 25'd5898240, 1'b0);
      send_entity(KIND_ARC, 0, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, {RADIUS_W{1'b1}},
                  25'd11796480, 25'd17694720, 1'b0);
      send_entity(KIND_ARC, 0, 0, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF, {RADIUS_W{1'b1}},
                  25'h1FF_FFFF, 25'd23592960, 1'b0);
      send_entity(KIND_ARC, 0, 0, 0, 0, 0, 0, 0, 25'd23592959, 25'd1, 1'b0);
      send_entity(KIND_CIRCLE, 0, 0, 0, 0, 0, 0, 31'h0010_0000, 0, 0, 1'b0);
      send_entity(KIND_CIRCLE, 0, 0, 0, 0, 32'h0003_0000, 0, 31'h0001_0000, 0, 0, 1'b0);
      send_entity(KIND_CIRCLE, 0, 0, 0, 0, 32'hFFFD_0000, 0, 31'h0001_0000, 0, 0, 1'b0);
      send_entity(KIND_CIRCLE, 0, 0, 0, 0, 0, 32'h0003_0000, 31'h0001_0000, 0, 0, 1'b0);
      send_entity(KIND_CIRCLE, 0, 0, 0, 0, 0, 32'h8000_0000, {RADIUS_W{1'b1}}, 0, 0, 1'b0);
      send_entity(KIND_CIRCLE, 0, 0, 0, 0, 32'h0004_0000, 32'hFFFD_0000, 0, 0, 0, 1'b0);
      send_entity(KIND_CIRCLE, 0, 0, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, {RADIUS_W{1'b1}},
                  0, 0, 1'b0);
      send_entity(KIND_CIRCLE, 0, 0, 0, 0, 32'h8000_0000, 32'h8000_0000, 31'h1, 0, 0, 1'b0);
      send_entity(KIND_CIRCLE, 0, 0, 0, 0, 32'h1, 32'hFFFF_FFFF, 31'h0, 0, 0, 1'b0);
      send_entity(KIND_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  RADIUS_W'($urandom), ANGLE_W'($urandom), ANGLE_W'($urandom), 1'b0);
      send_entity(KIND_LINE, 32'h1, 32'h2, 32'h3, 32'h4, 0, 0, 0, 0, 0, 1'b1);
      // random; items 1000..1300 run back to back
      while (sent < 2000) send_random(!(sent >= 1000 && sent < 1300));
      req_valid <= 1'b0;
      waited = 0;
      while (pending != 0 && waited < 100000) begin
         @(posedge clock);
         waited++;
      end
      repeat (200) @(posedge clock);
      $display("sent %0d entities (%0d arcs, %0d circles) over %0d cycles",
               sent, arcs_seen, circles_seen, cycle);
      if (errors == 0 && pending == 0) begin
         $display("PASS cad_entity_endpoint_converter");
      end else begin
         $display("%0d mismatches, %0d results missing", errors, pending);
         $display("FAIL cad_entity_endpoint_converter");
      end
      $finish;
   end

endmodule
